// ----- hdl/sorted_list_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted list engine assertion macros
// Shared concurrent assertion forms used by the sorted list engine modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted list engine package
// Types, codes and sizing constants shared by the cell and the top level.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT     = 3'd0,
      MODE_DELETE     = 3'd1,
      MODE_REMOVE_MIN = 3'd2,
      MODE_REMOVE_MAX = 3'd3,
      MODE_READ       = 3'd4,
      MODE_SEARCH     = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_BAD_POS   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_POP
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } state_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          item_position;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [STATUS_W-1:0]       status;
      logic                      found;
      logic [POS_W-1:0]          match_position;
      logic [POS_W-1:0]          entry_count;
   } rsp_type;

endpackage

// ----- hdl/sle_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted list engine cell
// Holds one entry, compares it against the broadcast value and takes its
// new entry from itself, a neighbor or the broadcast value.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic                      occupied,
   input  logic                      at_tail,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic                      left_gt,
   input  logic signed [VALUE_W-1:0] right_entry,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      gt,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   assign gt    = occupied && (entry_ff > cmd.value);
   assign eq    = occupied && (entry_ff == cmd.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
            end else if (gt || at_tail) begin
               entry_in = cmd.value;
            end
         end
         CELL_DELETE: begin
            if (gt || eq) begin
               entry_in = right_entry;
            end
         end
         CELL_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hdl/sorted_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// Sorted list engine core
// A request is accepted in the idle state and run in the execute state; the
// next is taken only after it has run. Execution is done by the row of cells:
// every cell compares its entry with the request value in parallel and loads
// from itself, a neighbor or the request, which is how values are inserted,
// deleted and removed from the head; removing the maximum only lowers the
// entry count. The result is held in an output register, so a new request is
// taken while the previous result waits; execution then stalls until it is
// taken. Reset clears state, result valid and count, with no clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_list_engine_core_macros.svh"

module sorted_list_engine_core import sle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   state_type           state_ff;
   state_type           state_in;
   req_type             req_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                load;
   cell_cmd_type        cmd;

   logic signed [VALUE_W-1:0] entry_v [CAPACITY];
   logic [CAPACITY-1:0]       gt_v;
   logic [CAPACITY-1:0]       eq_v;
   logic [CAPACITY-1:0]       first_eq_v;
   logic [CAPACITY-1:0]       occupied_v;
   logic [CAPACITY-1:0]       tail_v;

   logic                      any_eq;
   logic                      full;
   logic                      empty;
   logic                      bad_pos;
   logic [IDX_W-1:0]          rd_idx;
   logic signed [VALUE_W-1:0] rd_value;
   logic [POS_W-1:0]          match_pos;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [VALUE_W-1:0] left_entry;
         logic                      left_gt;
         logic signed [VALUE_W-1:0] right_entry;

         if (g == 0) begin : g_head
            assign left_entry = '0;
            assign left_gt    = 1'b0;
            assign first_eq_v[g] = eq_v[g];
         end else begin : g_body
            assign left_entry = entry_v[g-1];
            assign left_gt    = gt_v[g-1];
            assign first_eq_v[g] = eq_v[g] & ~eq_v[g-1];
         end

         if (g == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = entry_v[g+1];
         end

         assign occupied_v[g] = count_ff > COUNT_W'(g);
         assign tail_v[g]     = count_ff == COUNT_W'(g);

         sle_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occupied    (occupied_v[g]),
            .at_tail     (tail_v[g]),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (entry_v[g]),
            .gt          (gt_v[g]),
            .eq          (eq_v[g])
         );
      end
   endgenerate

   assign any_eq  = |eq_v;
   assign full    = count_ff >= COUNT_W'(CAPACITY);
   assign empty   = count_ff == '0;
   assign bad_pos = (req_ff.item_position == '0) ||
                    (CMP_W'(req_ff.item_position) > CMP_W'(count_ff));
   assign rd_idx  = (req_ff.mode == MODE_REMOVE_MAX) ?
                    IDX_W'(count_ff - COUNT_W'(1)) :
                    IDX_W'(req_ff.item_position - POS_W'(1));
   assign rd_value = entry_v[rd_idx];

   always_comb begin
      match_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_eq_v[i]) begin
            match_pos = match_pos | POS_W'(i + 1);
         end
      end
   end

   assign req_ready   = (state_ff == FSM_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      logic signed [VALUE_W-1:0] res;
      status_type                status;
      logic                      fnd;
      logic [POS_W-1:0]          mpos;

      state_in  = state_ff;
      load      = 1'b0;
      cmd.op    = CELL_HOLD;
      cmd.value = req_ff.item_value;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      res       = '0;
      status    = ST_OK;
      fnd       = 1'b0;
      mpos      = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = FSM_IDLE;
               unique case (req_ff.mode)
                  MODE_INSERT: begin
                     if (full) begin
                        status = ST_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (empty) begin
                        status = ST_UNDERFLOW;
                     end else if (!any_eq) begin
                        status = ST_NOT_FOUND;
                     end else begin
                        cmd.op   = CELL_DELETE;
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  MODE_REMOVE_MIN: begin
                     if (empty) begin
                        status = ST_UNDERFLOW;
                     end else begin
                        res      = entry_v[0];
                        cmd.op   = CELL_POP;
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  MODE_REMOVE_MAX: begin
                     if (empty) begin
                        status = ST_UNDERFLOW;
                     end else begin
                        res      = rd_value;
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  MODE_READ: begin
                     if (bad_pos) begin
                        status = ST_BAD_POS;
                     end else begin
                        res = rd_value;
                     end
                  end
                  MODE_SEARCH: begin
                     if (any_eq) begin
                        fnd  = 1'b1;
                        mpos = match_pos;
                     end
                  end
                  default: begin
                     status = ST_OK;
                  end
               endcase
               rsp_in.result_value   = res;
               rsp_in.status         = status;
               rsp_in.found          = fnd;
               rsp_in.match_position = mpos;
               rsp_in.entry_count    = POS_W'(count_in);
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   `SLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(CAPACITY), "entry count exceeds capacity")
   `SLE_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == FSM_EXEC, "accepted transaction did not enter execution")
   `SLE_ASSERT_NEXT(a_count_quiet, clock, reset, state_ff != FSM_EXEC, $stable(count_ff), "entry count changed outside execution")
   `SLE_ASSERT_NOW(a_rsp_count, clock, reset, rsp_valid_ff, rsp_ff.entry_count == POS_W'(count_ff), "pending result disagrees with entry count")

endmodule

// ----- sim/sorted_list_engine_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list engine core testbench
// Drives insert, delete, remove min, remove max, read and search transactions
// into the engine and checks every response against a behavioral copy of the
// sorted store. A directed opening covers empty and edge values. Random
// traffic follows in fill-heavy, drain-heavy and mixed blocks under several
// sender idle and receiver stall patterns, including one long receiver hold.
// ----------------------------------------------------------------------------
module sorted_list_engine_core_tb import sle_pkg::*; ();

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam int BLOCK_ITEMS = 40;
   localparam int HOLD_CYCLES = 500;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   logic signed [VALUE_W-1:0] list_entries[CAPACITY];
   int      list_count = 0;
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      req_taken = 1'b0;
   bit      hold_arm = 1'b0;
   bit      hold_used = 1'b0;
   int      hold_left = 0;

   sorted_list_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Index of the first entry equal to v, or the entry count if none.
   function automatic int list_find(logic signed [VALUE_W-1:0] v);
      int i;
      for (i = 0; i < list_count; i++) begin
         if (list_entries[i] == v) return i;
         if (list_entries[i] > v) break;
      end
      return list_count;
   endfunction

   function automatic void list_remove_at(int idx);
      int i;
      for (i = idx; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
      list_count--;
   endfunction

   function automatic rsp_type list_apply(req_type r);
      rsp_type o;
      int      i;
      int      k;
      o = '0;
      o.status = ST_OK;
      case (r.mode)
         MODE_INSERT: begin
            if (list_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               k = list_count;
               for (i = 0; i < list_count; i++) begin
                  if (list_entries[i] > r.item_value) begin
                     k = i;
                     break;
                  end
               end
               for (i = list_count; i > k; i--) list_entries[i] = list_entries[i - 1];
               list_entries[k] = r.item_value;
               list_count++;
            end
         end
         MODE_DELETE: begin
            if (list_count == 0) begin
               o.status = ST_UNDERFLOW;
            end else begin
               k = list_find(r.item_value);
               if (k >= list_count) o.status = ST_NOT_FOUND;
               else list_remove_at(k);
            end
         end
         MODE_REMOVE_MIN: begin
            if (list_count == 0) begin
               o.status = ST_UNDERFLOW;
            end else begin
               o.result_value = list_entries[0];
               list_remove_at(0);
            end
         end
         MODE_REMOVE_MAX: begin
            if (list_count == 0) begin
               o.status = ST_UNDERFLOW;
            end else begin
               o.result_value = list_entries[list_count - 1];
               list_count--;
            end
         end
         MODE_READ: begin
            if (r.item_position < 1 || r.item_position > list_count) begin
               o.status = ST_BAD_POS;
            end else begin
               o.result_value = list_entries[r.item_position - 1];
            end
         end
         MODE_SEARCH: begin
            k = list_find(r.item_value);
            if (k < list_count) begin
               o.found = 1'b1;
               o.match_position = POS_W'(k + 1);
            end
         end
         default: ;
      endcase
      o.entry_count = POS_W'(list_count);
      return o;
   endfunction

   function automatic req_type make_req(logic [MODE_W-1:0] m, logic signed [VALUE_W-1:0] v,
                                        logic [POS_W-1:0] p);
      req_type r;
      r.mode = m;
      r.item_value = v;
      r.item_position = p;
      return r;
   endfunction

   // Values mostly come from a small pool so that duplicates, deletes and
   // searches hit stored entries.
   function automatic req_type random_req(int insert_pct);
      logic [MODE_W-1:0]         m;
      logic signed [VALUE_W-1:0] v;
      logic [POS_W-1:0]          p;
      int                        r;
      r = $urandom_range(99);
      if (r < insert_pct) begin
         m = MODE_INSERT;
      end else begin
         case ($urandom_range(15))
            0, 1, 2:  m = MODE_DELETE;
            3, 4, 5:  m = MODE_REMOVE_MIN;
            6, 7, 8:  m = MODE_REMOVE_MAX;
            9, 10, 11: m = MODE_READ;
            12, 13, 14: m = MODE_SEARCH;
            default:  m = ($urandom_range(1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
         endcase
      end
      r = $urandom_range(99);
      if (r < 60) v = VALUE_W'($signed($urandom_range(7)) - 3);
      else if (r < 70) v = ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
      else v = $urandom;
      if ($urandom_range(99) < 80) p = POS_W'($urandom_range(17));
      else p = POS_W'($urandom_range(31));
      return make_req(m, v, p);
   endfunction

   function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               report_field("result_value", exp_rsp.result_value, rsp_payload.result_value);
               report_field("status", exp_rsp.status, rsp_payload.status);
               report_field("found", exp_rsp.found, rsp_payload.found);
               report_field("match_position", exp_rsp.match_position,
                            rsp_payload.match_position);
               report_field("entry_count", exp_rsp.entry_count, rsp_payload.entry_count);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(list_apply(req_payload));
            req_taken = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      int blk;
      int n;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (blk = 0; blk < 6; blk++) begin
         for (n = 0; n < BLOCK_ITEMS; n++) begin
            case (blk % 3)
               0: pending_reqs.push_back(random_req(85));
               1: pending_reqs.push_back(random_req(10));
               default: pending_reqs.push_back(random_req(45));
            endcase
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(make_req(MODE_READ, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE_MIN, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE_MAX, 0, 0));
      pending_reqs.push_back(make_req(MODE_DELETE, 5, 0));
      pending_reqs.push_back(make_req(MODE_SEARCH, 5, 0));
      pending_reqs.push_back(make_req(MODE_INSERT, VAL_MAX, 0));
      pending_reqs.push_back(make_req(MODE_INSERT, VAL_MIN, 0));
      pending_reqs.push_back(make_req(MODE_INSERT, 0, 0));
      pending_reqs.push_back(make_req(MODE_INSERT, 0, 31));
      pending_reqs.push_back(make_req(MODE_INSERT, -1, 0));
      pending_reqs.push_back(make_req(MODE_SEARCH, 0, 0));
      pending_reqs.push_back(make_req(MODE_SEARCH, 7, 0));
      pending_reqs.push_back(make_req(MODE_READ, 0, 1));
      pending_reqs.push_back(make_req(MODE_READ, 0, 5));
      pending_reqs.push_back(make_req(MODE_READ, 0, 6));
      pending_reqs.push_back(make_req(MODE_READ, 0, 31));
      pending_reqs.push_back(make_req(MODE_DELETE, 9, 0));
      pending_reqs.push_back(make_req(MODE_DELETE, 0, 0));
      pending_reqs.push_back(make_req(MODE_SPARE_A, VAL_MAX, 31));
      pending_reqs.push_back(make_req(MODE_SPARE_B, VAL_MIN, 16));
      pending_reqs.push_back(make_req(MODE_REMOVE_MAX, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE_MIN, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE_MIN, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE_MAX, 0, 0));
      wait_drained();

      run_phase(0, 0);
      run_phase(60, 0);
      run_phase(0, 60);
      run_phase(35, 35);
      hold_arm = 1'b1;
      run_phase(0, 20);

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
